// ----- hw/rtl/efg_pkg.sv -----
// Shared types, constants and register codes of the Ethernet frame generator.
package efg_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 9000;
   localparam int unsigned QUEUE_DEPTH     = 4;

   localparam logic [13:0] MIN_FRAME_BYTES = 14'd64;
   localparam logic [13:0] ARP_FRAME_BYTES = 14'd42;
   localparam logic [13:0] ETH_HEADER_BYTES = 14'd14;
   localparam logic [13:0] IP_UDP_HEADER_BYTES = 14'd34;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETHERTYPE_VLAN = 16'h8100;
   localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
   localparam logic [15:0] ARP_HW_ETHER   = 16'h0001;
   localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
   localparam logic [7:0]  ARP_HW_LEN     = 8'd6;
   localparam logic [7:0]  ARP_PROTO_LEN  = 8'd4;
   localparam logic [15:0] TCP_WINDOW     = 16'd5840;
   localparam logic [7:0]  TCP_DATA_OFFSET = 8'h50;
   localparam logic [7:0]  TCP_FLAG_SYN   = 8'h02;
   localparam logic [7:0]  IP_VER_IHL     = 8'h45;
   localparam logic [7:0]  IP_TTL         = 8'd64;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_NONE     = 8'hff;

   // Frame kinds; the remaining codes build a raw frame.
   localparam logic [2:0] KIND_RAW  = 3'd0;
   localparam logic [2:0] KIND_UDP  = 3'd1;
   localparam logic [2:0] KIND_TCP  = 3'd2;
   localparam logic [2:0] KIND_VLAN = 3'd3;
   localparam logic [2:0] KIND_ARP  = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_FRAME_SIZE   = 3'd0;
   localparam logic [2:0] REG_FRAME_KIND   = 3'd1;
   localparam logic [2:0] REG_DEST_MAC     = 3'd2;
   localparam logic [2:0] REG_SOURCE_MAC   = 3'd3;
   localparam logic [2:0] REG_DEST_IPV4    = 3'd4;
   localparam logic [2:0] REG_SOURCE_IPV4  = 3'd5;
   localparam logic [2:0] REG_PORT_PAIR    = 3'd6;
   localparam logic [2:0] REG_VLAN_TCI     = 3'd7;

   typedef struct packed {
      logic [13:0] frame_size;
      logic [2:0]  frame_kind;
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [31:0] dest_ipv4;
      logic [31:0] source_ipv4;
      logic [31:0] port_pair;
      logic [15:0] vlan_tag_control;
   } csr_type;

   localparam csr_type CSR_RESET = '{
      frame_size:       14'd512,
      frame_kind:       KIND_RAW,
      dest_mac:         48'hffff_ffff_ffff,
      source_mac:       48'h0,
      dest_ipv4:        32'hc0a8_0101,
      source_ipv4:      32'hc0a8_0102,
      port_pair:        32'd809042000,
      vlan_tag_control: 16'd1
   };

   // Where the back end takes a byte from.
   typedef enum logic [3:0] {
      SEL_LIT,
      SEL_DMAC,
      SEL_SMAC,
      SEL_DIP,
      SEL_SIP,
      SEL_PORT,
      SEL_TCI,
      SEL_IDENT,
      SEL_CSUM,
      SEL_SEQ
   } sel_type;

   typedef struct packed {
      sel_type    sel;
      logic [2:0] idx;
      logic [7:0] lit;
      logic       start;
      logic       last;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] ident;
      logic [15:0] ip_len;
      logic [7:0]  proto;
   } csum_req_type;

endpackage

// ----- hw/rtl/ethernet_frame_generator.sv -----
// Ethernet frame generator top level: one frame byte out for every beat in.
// A beat is classified into the queue, then byte-selected into the output register.
// Throughput: one beat per cycle while the queue has room and the output is taken, set by
// the combinational classify and byte-select paths.
// The IPv4 header checksum of a frame is computed in the adder pipeline from its first beat.
// Reset clears the byte position, the queue and the output register, and loads the
// configuration registers with their defaults.
module ethernet_frame_generator #(
   parameter int unsigned MAX_FRAME_BYTES = efg_pkg::MAX_FRAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_ident_value,
   input  logic [31:0] req_sequence_value,
   input  logic [7:0]  req_fill_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_frame_start,
   output logic        rsp_frame_end,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_write_data
);

   efg_pkg::csr_type      csr_ff, csr_in;
   efg_pkg::item_type     push_item;
   efg_pkg::item_type     pop_item;
   efg_pkg::csum_req_type csum_req;
   logic                  req_accept;
   logic                  fifo_full;
   logic                  fifo_empty;
   logic                  fifo_pop;
   logic [15:0]           held_ident;
   logic [31:0]           held_sequence;
   logic [15:0]           checksum;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            efg_pkg::REG_FRAME_SIZE:  csr_in.frame_size       = csr_write_data[13:0];
            efg_pkg::REG_FRAME_KIND:  csr_in.frame_kind       = csr_write_data[2:0];
            efg_pkg::REG_DEST_MAC:    csr_in.dest_mac         = csr_write_data;
            efg_pkg::REG_SOURCE_MAC:  csr_in.source_mac       = csr_write_data;
            efg_pkg::REG_DEST_IPV4:   csr_in.dest_ipv4        = csr_write_data[31:0];
            efg_pkg::REG_SOURCE_IPV4: csr_in.source_ipv4      = csr_write_data[31:0];
            efg_pkg::REG_PORT_PAIR:   csr_in.port_pair        = csr_write_data[31:0];
            efg_pkg::REG_VLAN_TCI:    csr_in.vlan_tag_control = csr_write_data[15:0];
            default:                  csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= efg_pkg::CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign req_full   = fifo_full;
   assign req_accept = req_push && !fifo_full;

   efg_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .frame_size       (csr_ff.frame_size),
      .frame_kind       (csr_ff.frame_kind),
      .ident_value      (req_ident_value),
      .sequence_value   (req_sequence_value),
      .fill_byte        (req_fill_byte),
      .item             (push_item),
      .csum_req         (csum_req),
      .held_ident_ff    (held_ident),
      .held_sequence_ff (held_sequence)
   );

   efg_csum u_csum (
      .clock       (clock),
      .reset       (reset),
      .csum_req    (csum_req),
      .source_ipv4 (csr_ff.source_ipv4),
      .dest_ipv4   (csr_ff.dest_ipv4),
      .checksum_ff (checksum)
   );

   efg_fifo #(
      .DEPTH(efg_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_item  (pop_item),
      .empty     (fifo_empty)
   );

   efg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item            (pop_item),
      .queue_empty     (fifo_empty),
      .queue_pop       (fifo_pop),
      .csr             (csr_ff),
      .held_ident      (held_ident),
      .held_sequence   (held_sequence),
      .checksum        (checksum),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_end   (rsp_frame_end)
   );

   // No frame is a single beat long, so a beat is never both first and last.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !(push_item.start && push_item.last))
      else $error("beat classified as both first and last of a frame");

   // After reset, the output is empty and the input side takes beats.
   assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("output or queue not empty after reset");

   // With nothing queued, a taken result leaves the output register empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && fifo_empty) |=> rsp_empty)
      else $error("output register shows a beat that was never queued");

endmodule

// ----- hw/rtl/efg_fifo.sv -----
// Short queue of classified beats between the front and the back end.
module efg_fifo #(
   parameter int unsigned DEPTH = efg_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  efg_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output efg_pkg::item_type pop_item,
   output logic              empty
);

   localparam int unsigned PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountBits = $clog2(DEPTH + 1);

   efg_pkg::item_type      entry_ff [DEPTH];
   logic [PtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = entry_ff[rd_ptr_ff];
   assign full     = (count_ff == CountBits'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

// ----- hw/rtl/efg_front.sv -----
// Front end: tracks the byte position, latches per-frame fields and classifies each beat.
module efg_front #(
   parameter int unsigned MAX_FRAME_BYTES = efg_pkg::MAX_FRAME_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [13:0]           frame_size,
   input  logic [2:0]            frame_kind,
   input  logic [15:0]           ident_value,
   input  logic [31:0]           sequence_value,
   input  logic [7:0]            fill_byte,
   output efg_pkg::item_type     item,
   output efg_pkg::csum_req_type csum_req,
   output logic [15:0]           held_ident_ff,
   output logic [31:0]           held_sequence_ff
);

   localparam logic [13:0] MaxSize = 14'(MAX_FRAME_BYTES);

   logic [13:0] pos_ff, pos_in;
   logic [13:0] size;
   logic [13:0] frame_len;
   logic [14:0] pos_plus;
   logic        is_start;
   logic        is_last;
   logic [15:0] ip_len;
   logic [15:0] udp_len;
   logic [15:0] eth_type_code;
   logic [7:0]  proto;
   logic [13:0] off6;
   logic [13:0] q;
   logic [13:0] t;
   logic [13:0] q_minus8;
   logic [13:0] q_minus14;
   logic [13:0] q_minus24;

   always_comb begin
      if (frame_size < efg_pkg::MIN_FRAME_BYTES) begin
         size = efg_pkg::MIN_FRAME_BYTES;
      end else if (frame_size > MaxSize) begin
         size = MaxSize;
      end else begin
         size = frame_size;
      end
      frame_len = (frame_kind == efg_pkg::KIND_ARP) ? efg_pkg::ARP_FRAME_BYTES : size;
      pos_plus  = {1'b0, pos_ff} + 15'd1;
      is_start  = (pos_ff == '0);
      is_last   = (pos_plus >= {1'b0, frame_len});
      pos_in    = is_last ? '0 : pos_plus[13:0];

      ip_len  = {2'b00, size - efg_pkg::ETH_HEADER_BYTES};
      udp_len = {2'b00, size - efg_pkg::IP_UDP_HEADER_BYTES};

      if (frame_kind == efg_pkg::KIND_UDP) begin
         proto = efg_pkg::PROTO_UDP;
      end else if (frame_kind == efg_pkg::KIND_TCP) begin
         proto = efg_pkg::PROTO_TCP;
      end else begin
         proto = efg_pkg::PROTO_NONE;
      end

      if (frame_kind == efg_pkg::KIND_VLAN) begin
         eth_type_code = efg_pkg::ETHERTYPE_VLAN;
      end else if (frame_kind == efg_pkg::KIND_ARP) begin
         eth_type_code = efg_pkg::ETHERTYPE_ARP;
      end else begin
         eth_type_code = efg_pkg::ETHERTYPE_IPV4;
      end

      off6      = pos_ff - 14'd6;
      q         = pos_ff - 14'd14;
      t         = q - 14'd20;
      q_minus8  = q - 14'd8;
      q_minus14 = q - 14'd14;
      q_minus24 = q - 14'd24;

      // Even offsets inside a two-byte field carry its high byte.
      item.sel   = efg_pkg::SEL_LIT;
      item.idx   = '0;
      item.lit   = fill_byte;
      item.start = is_start;
      item.last  = is_last;

      if (pos_ff < 14'd6) begin
         item.sel = efg_pkg::SEL_DMAC;
         item.idx = pos_ff[2:0];
      end else if (pos_ff < 14'd12) begin
         item.sel = efg_pkg::SEL_SMAC;
         item.idx = off6[2:0];
      end else if (pos_ff < 14'd14) begin
         item.lit = pos_ff[0] ? eth_type_code[7:0] : eth_type_code[15:8];
      end else if (frame_kind == efg_pkg::KIND_VLAN) begin
         if (q < 14'd2) begin
            item.sel = efg_pkg::SEL_TCI;
            item.idx = q[2:0];
         end else if (q < 14'd4) begin
            item.lit = q[0] ? efg_pkg::ETHERTYPE_IPV4[7:0] : efg_pkg::ETHERTYPE_IPV4[15:8];
         end
      end else if (frame_kind == efg_pkg::KIND_ARP) begin
         if (q < 14'd2) begin
            item.lit = q[0] ? efg_pkg::ARP_HW_ETHER[7:0] : efg_pkg::ARP_HW_ETHER[15:8];
         end else if (q < 14'd4) begin
            item.lit = q[0] ? efg_pkg::ETHERTYPE_IPV4[7:0] : efg_pkg::ETHERTYPE_IPV4[15:8];
         end else if (q == 14'd4) begin
            item.lit = efg_pkg::ARP_HW_LEN;
         end else if (q == 14'd5) begin
            item.lit = efg_pkg::ARP_PROTO_LEN;
         end else if (q < 14'd8) begin
            item.lit = q[0] ? efg_pkg::ARP_OP_REQUEST[7:0] : efg_pkg::ARP_OP_REQUEST[15:8];
         end else if (q < 14'd14) begin
            item.sel = efg_pkg::SEL_SMAC;
            item.idx = q_minus8[2:0];
         end else if (q < 14'd18) begin
            item.sel = efg_pkg::SEL_SIP;
            item.idx = q_minus14[2:0];
         end else if (q < 14'd24) begin
            item.lit = 8'h00;
         end else if (q < 14'd28) begin
            item.sel = efg_pkg::SEL_DIP;
            item.idx = q_minus24[2:0];
         end else begin
            item.lit = 8'h00;
         end
      end else if (frame_kind == efg_pkg::KIND_UDP || frame_kind == efg_pkg::KIND_TCP) begin
         if (q < 14'd20) begin
            unique case (q[4:0])
               5'd0:  item.lit = efg_pkg::IP_VER_IHL;
               5'd2:  item.lit = ip_len[15:8];
               5'd3:  item.lit = ip_len[7:0];
               5'd4, 5'd5: begin
                  item.sel = efg_pkg::SEL_IDENT;
                  item.idx = {2'b00, q[0]};
               end
               5'd8:  item.lit = efg_pkg::IP_TTL;
               5'd9:  item.lit = proto;
               5'd10, 5'd11: begin
                  item.sel = efg_pkg::SEL_CSUM;
                  item.idx = {2'b00, q[0]};
               end
               5'd12, 5'd13, 5'd14, 5'd15: begin
                  item.sel = efg_pkg::SEL_SIP;
                  item.idx = {1'b0, q[1:0]};
               end
               5'd16, 5'd17, 5'd18, 5'd19: begin
                  item.sel = efg_pkg::SEL_DIP;
                  item.idx = {1'b0, q[1:0]};
               end
               default: item.lit = 8'h00;
            endcase
         end else if (t < 14'd4) begin
            item.sel = efg_pkg::SEL_PORT;
            item.idx = t[2:0];
         end else if (frame_kind == efg_pkg::KIND_UDP) begin
            if (t < 14'd6) begin
               item.lit = t[0] ? udp_len[7:0] : udp_len[15:8];
            end else if (t < 14'd8) begin
               item.lit = 8'h00;
            end
         end else begin
            if (t < 14'd8) begin
               item.sel = efg_pkg::SEL_SEQ;
               item.idx = {1'b0, t[1:0]};
            end else if (t < 14'd12) begin
               item.lit = 8'h00;
            end else if (t == 14'd12) begin
               item.lit = efg_pkg::TCP_DATA_OFFSET;
            end else if (t == 14'd13) begin
               item.lit = efg_pkg::TCP_FLAG_SYN;
            end else if (t < 14'd16) begin
               item.lit = t[0] ? efg_pkg::TCP_WINDOW[7:0] : efg_pkg::TCP_WINDOW[15:8];
            end else if (t < 14'd20) begin
               item.lit = 8'h00;
            end
         end
      end

      csum_req.valid  = accept && is_start;
      csum_req.ident  = ident_value;
      csum_req.ip_len = ip_len;
      csum_req.proto  = proto;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_start) begin
         held_ident_ff    <= ident_value;
         held_sequence_ff <= sequence_value;
      end
   end

endmodule

// ----- hw/rtl/efg_csum.sv -----
// IPv4 header checksum unit: a three-stage adder pipeline started at each frame's first beat.
module efg_csum (
   input  logic                  clock,
   input  logic                  reset,
   input  efg_pkg::csum_req_type csum_req,
   input  logic [31:0]           source_ipv4,
   input  logic [31:0]           dest_ipv4,
   output logic [15:0]           checksum_ff
);

   logic [17:0] sum_a_ff, sum_a_in;
   logic [17:0] sum_b_ff, sum_b_in;
   logic [18:0] sum_ff, sum_in;
   logic        stage1_ff;
   logic        stage2_ff;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] checksum_in;

   always_comb begin
      sum_a_in = {2'b00, efg_pkg::IP_VER_IHL, 8'h00} + {2'b00, csum_req.ip_len}
               + {2'b00, csum_req.ident} + {2'b00, efg_pkg::IP_TTL, csum_req.proto};
      sum_b_in = {2'b00, source_ipv4[31:16]} + {2'b00, source_ipv4[15:0]}
               + {2'b00, dest_ipv4[31:16]} + {2'b00, dest_ipv4[15:0]};
      sum_in   = {1'b0, sum_a_ff} + {1'b0, sum_b_ff};
      // Two end-around carry folds; the first leaves at most one carry bit.
      fold1       = {14'b0, sum_ff[18:16]} + {1'b0, sum_ff[15:0]};
      fold2       = fold1[15:0] + {15'b0, fold1[16]};
      checksum_in = ~fold2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff   <= 1'b0;
         stage2_ff   <= 1'b0;
         checksum_ff <= '0;
      end else begin
         stage1_ff <= csum_req.valid;
         stage2_ff <= stage1_ff;
         if (stage2_ff) begin
            checksum_ff <= checksum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (csum_req.valid) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
      if (stage1_ff) begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ----- hw/rtl/efg_back.sv -----
// Back end: picks each beat's byte from its literal, the registers or held fields into the output register.
module efg_back (
   input  logic              clock,
   input  logic              reset,
   input  efg_pkg::item_type item,
   input  logic              queue_empty,
   output logic              queue_pop,
   input  efg_pkg::csr_type  csr,
   input  logic [15:0]       held_ident,
   input  logic [31:0]       held_sequence,
   input  logic [15:0]       checksum,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [7:0]        rsp_frame_byte,
   output logic              rsp_frame_start,
   output logic              rsp_frame_end
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       start_ff;
   logic       last_ff;

   // Byte idx of a big-endian field whose last byte has index top_idx.
   function automatic logic [7:0] pick_byte(logic [47:0] value, logic [2:0] top_idx,
                                            logic [2:0] idx);
      logic [47:0] shifted;
      logic [2:0]  lane;
      lane    = top_idx - idx;
      shifted = value >> {lane, 3'b000};
      return shifted[7:0];
   endfunction

   always_comb begin
      unique case (item.sel)
         efg_pkg::SEL_LIT:   byte_in = item.lit;
         efg_pkg::SEL_DMAC:  byte_in = pick_byte(csr.dest_mac, 3'd5, item.idx);
         efg_pkg::SEL_SMAC:  byte_in = pick_byte(csr.source_mac, 3'd5, item.idx);
         efg_pkg::SEL_DIP:   byte_in = pick_byte({16'b0, csr.dest_ipv4}, 3'd3, item.idx);
         efg_pkg::SEL_SIP:   byte_in = pick_byte({16'b0, csr.source_ipv4}, 3'd3, item.idx);
         efg_pkg::SEL_PORT:  byte_in = pick_byte({16'b0, csr.port_pair}, 3'd3, item.idx);
         efg_pkg::SEL_TCI:   byte_in = pick_byte({32'b0, csr.vlan_tag_control}, 3'd1,
                                                 item.idx);
         efg_pkg::SEL_IDENT: byte_in = pick_byte({32'b0, held_ident}, 3'd1, item.idx);
         efg_pkg::SEL_CSUM:  byte_in = pick_byte({32'b0, checksum}, 3'd1, item.idx);
         efg_pkg::SEL_SEQ:   byte_in = pick_byte({16'b0, held_sequence}, 3'd3, item.idx);
         default:            byte_in = item.lit;
      endcase

      queue_pop    = !queue_empty && (!out_valid_ff || rsp_pop);
      out_valid_in = queue_pop || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         byte_ff  <= byte_in;
         start_ff <= item.start;
         last_ff  <= item.last;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_frame_byte  = byte_ff;
   assign rsp_frame_start = start_ff;
   assign rsp_frame_end   = last_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Ethernet frame generator: predicted bytes vs. the rsp queue.
module tb_top;
   import efg_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 6;
   // Kind codes with no layout of their own; the block sends a raw frame for them.
   localparam logic [2:0] KIND_SPARE     = 3'd6;
   localparam logic [2:0] KIND_SPARE_TOP = 3'd7;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_start;
      logic       frame_end;
   } frame_beat_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_push           = 1'b0;
   logic        req_full;
   logic [15:0] req_ident_value    = '0;
   logic [31:0] req_sequence_value = '0;
   logic [7:0]  req_fill_byte      = '0;
   logic        rsp_empty;
   logic        rsp_pop            = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_frame_start;
   logic        rsp_frame_end;
   logic        csr_write_enable   = 1'b0;
   logic [2:0]  csr_index          = REG_FRAME_SIZE;
   logic [47:0] csr_write_data     = '0;

   // Predictor state: register copy, byte position and the values held per frame.
   csr_type     model_csr      = CSR_RESET;
   logic [13:0] frame_position = '0;
   logic [15:0] held_ident     = '0;
   logic [31:0] held_sequence  = '0;
   logic [15:0] held_checksum  = '0;
   frame_beat_type expected_beats[$];

   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned phase_count    = 0;

   ethernet_frame_generator dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_ident_value    (req_ident_value),
      .req_sequence_value (req_sequence_value),
      .req_fill_byte      (req_fill_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_frame_start    (rsp_frame_start),
      .rsp_frame_end      (rsp_frame_end),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned effective_size();
      if (model_csr.frame_size < MIN_FRAME_BYTES) return MIN_FRAME_BYTES;
      if (model_csr.frame_size > MAX_FRAME_BYTES) return MAX_FRAME_BYTES;
      return model_csr.frame_size;
   endfunction

   function automatic int unsigned frame_length();
      return (model_csr.frame_kind == KIND_ARP) ? ARP_FRAME_BYTES : effective_size();
   endfunction

   function automatic int unsigned bytes_left();
      if (frame_position >= frame_length()) return 1;
      return frame_length() - frame_position;
   endfunction

   function automatic logic [7:0] ip_protocol();
      if (model_csr.frame_kind == KIND_UDP) return PROTO_UDP;
      if (model_csr.frame_kind == KIND_TCP) return PROTO_TCP;
      return PROTO_NONE;
   endfunction

   // Octet 'index' of a big-endian field 'width_bytes' wide.
   function automatic logic [7:0] be_octet(logic [47:0] value, int unsigned width_bytes,
                                           int unsigned index);
      logic [47:0] shifted;
      shifted = value >> (8 * (width_bytes - 1 - index));
      return shifted[7:0];
   endfunction

   function automatic logic [15:0] header_sum(int unsigned size);
      logic [31:0] sum;
      sum = {IP_VER_IHL, 8'h00};
      sum += (size - 14) & 32'h0000_ffff;
      sum += held_ident;
      sum += {IP_TTL, ip_protocol()};
      sum += model_csr.source_ipv4[31:16];
      sum += model_csr.source_ipv4[15:0];
      sum += model_csr.dest_ipv4[31:16];
      sum += model_csr.dest_ipv4[15:0];
      sum = (sum >> 16) + (sum & 32'h0000_ffff);
      sum += sum >> 16;
      return ~sum[15:0];
   endfunction

   function automatic logic [7:0] layout_byte(int unsigned pos, int unsigned size,
                                              logic [7:0] fill);
      int unsigned q;
      int unsigned t;
      logic [15:0] etype;
      if (pos < 6) return be_octet(model_csr.dest_mac, 6, pos);
      if (pos < 12) return be_octet(model_csr.source_mac, 6, pos - 6);
      if (pos < 14) begin
         etype = ETHERTYPE_IPV4;
         if (model_csr.frame_kind == KIND_VLAN) etype = ETHERTYPE_VLAN;
         else if (model_csr.frame_kind == KIND_ARP) etype = ETHERTYPE_ARP;
         return be_octet(etype, 2, pos - 12);
      end
      q = pos - 14;
      if (model_csr.frame_kind == KIND_VLAN) begin
         if (q < 2) return be_octet(model_csr.vlan_tag_control, 2, q);
         if (q < 4) return be_octet(ETHERTYPE_IPV4, 2, q - 2);
         return fill;
      end
      if (model_csr.frame_kind == KIND_ARP) begin
         if (q < 2) return be_octet(ARP_HW_ETHER, 2, q);
         if (q < 4) return be_octet(ETHERTYPE_IPV4, 2, q - 2);
         if (q == 4) return ARP_HW_LEN;
         if (q == 5) return ARP_PROTO_LEN;
         if (q < 8) return be_octet(ARP_OP_REQUEST, 2, q - 6);
         if (q < 14) return be_octet(model_csr.source_mac, 6, q - 8);
         if (q < 18) return be_octet(model_csr.source_ipv4, 4, q - 14);
         if (q < 24) return 8'h00;
         if (q < 28) return be_octet(model_csr.dest_ipv4, 4, q - 24);
         // A kind change can leave the position beyond the ARP body.
         return 8'h00;
      end
      if (model_csr.frame_kind != KIND_UDP && model_csr.frame_kind != KIND_TCP) return fill;
      if (q < 2) return (q == 0) ? IP_VER_IHL : 8'h00;
      if (q < 4) return be_octet(size - 14, 2, q - 2);
      if (q < 6) return be_octet(held_ident, 2, q - 4);
      if (q < 8) return 8'h00;
      if (q == 8) return IP_TTL;
      if (q == 9) return ip_protocol();
      if (q < 12) return be_octet(held_checksum, 2, q - 10);
      if (q < 16) return be_octet(model_csr.source_ipv4, 4, q - 12);
      if (q < 20) return be_octet(model_csr.dest_ipv4, 4, q - 16);
      t = q - 20;
      if (t < 4) return be_octet(model_csr.port_pair, 4, t);
      if (model_csr.frame_kind == KIND_UDP) begin
         if (t < 6) return be_octet(size - IP_UDP_HEADER_BYTES, 2, t - 4);
         if (t < 8) return 8'h00;
         return fill;
      end
      if (t < 8) return be_octet(held_sequence, 4, t - 4);
      if (t < 12) return 8'h00;
      if (t == 12) return TCP_DATA_OFFSET;
      if (t == 13) return TCP_FLAG_SYN;
      if (t < 16) return be_octet(TCP_WINDOW, 2, t - 14);
      if (t < 20) return 8'h00;
      return fill;
   endfunction

   task automatic predict_frame_byte(input logic [15:0] ident, input logic [31:0] seq_value,
                                     input logic [7:0] fill);
      int unsigned size;
      int unsigned len;
      int unsigned pos;
      frame_beat_type beat;
      size = effective_size();
      len  = frame_length();
      pos  = frame_position;
      if (pos == 0) begin
         held_ident    = ident;
         held_sequence = seq_value;
         held_checksum = header_sum(size);
      end
      beat.frame_byte  = layout_byte(pos, size, fill);
      beat.frame_start = (pos == 0);
      beat.frame_end   = (pos + 1 >= len);
      frame_position   = beat.frame_end ? 14'd0 : 14'(pos + 1);
      expected_beats.push_back(beat);
   endtask

   task automatic apply_csr(input logic [2:0] index, input logic [47:0] data);
      case (index)
         REG_FRAME_SIZE:  model_csr.frame_size       = data[13:0];
         REG_FRAME_KIND:  model_csr.frame_kind       = data[2:0];
         REG_DEST_MAC:    model_csr.dest_mac         = data;
         REG_SOURCE_MAC:  model_csr.source_mac       = data;
         REG_DEST_IPV4:   model_csr.dest_ipv4        = data[31:0];
         REG_SOURCE_IPV4: model_csr.source_ipv4      = data[31:0];
         REG_PORT_PAIR:   model_csr.port_pair        = data[31:0];
         REG_VLAN_TCI:    model_csr.vlan_tag_control = data[15:0];
         default: ;
      endcase
   endtask

   // Called at a falling edge with the block idle.
   task automatic write_csr(input logic [2:0] index, input logic [47:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      apply_csr(index, data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic [15:0] ident, input logic [31:0] seq_value,
                            input logic [7:0] fill);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push           = 1'b1;
      req_ident_value    = ident;
      req_sequence_value = seq_value;
      req_fill_byte      = fill;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_frame_byte(ident, seq_value, fill);
      @(negedge clock);
   endtask

   task automatic send_random_beat();
      send_beat(16'($urandom), $urandom, 8'($urandom));
   endtask

   task automatic wait_drained();
      req_push = 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Ethernet header under the reset values of every register.
   task automatic test_reset_config();
      send_beat(16'hffff, 32'hffff_ffff, 8'h00);
      repeat (13) send_random_beat();
   endtask

   // Oversized length saturates; then ARP is selected with the position past its body.
   task automatic test_size_ceiling_arp_cut();
      wait_drained();
      write_csr(REG_FRAME_SIZE, 48'hffff_ffff_ffff);
      write_csr(REG_FRAME_KIND, {45'h0, KIND_UDP});
      write_csr(REG_DEST_MAC, 48'hffff_ffff_ffff);
      write_csr(REG_SOURCE_MAC, 48'h0);
      write_csr(REG_DEST_IPV4, 48'hffff_ffff);
      write_csr(REG_SOURCE_IPV4, 48'h0);
      write_csr(REG_PORT_PAIR, 48'hffff_0000);
      write_csr(REG_VLAN_TCI, 48'hffff);
      while (frame_position < 44)
         send_beat(16'($urandom), $urandom, frame_position[0] ? 8'hff : 8'h00);
      wait_drained();
      write_csr(REG_FRAME_KIND, {45'h0, KIND_ARP});
      send_random_beat();
   endtask

   // Below-minimum size and an unused kind code; upper write-data bits are junk.
   task automatic test_unknown_kind_floor();
      wait_drained();
      write_csr(REG_FRAME_SIZE, 48'hffff_ffff_c000);
      write_csr(REG_FRAME_KIND, {45'h1fff_ffff_ffff, KIND_SPARE_TOP});
      send_beat(16'h0000, 32'h0000_0000, 8'hff);
      repeat (13) send_random_beat();
   endtask

   function automatic logic [2:0] phase_kind(int unsigned phase);
      case (phase % 6)
         0:       return KIND_UDP;
         1:       return KIND_TCP;
         2:       return KIND_VLAN;
         3:       return KIND_ARP;
         4:       return KIND_SPARE;
         default: return KIND_RAW;
      endcase
   endfunction

   task automatic test_random_frames(input int unsigned send_pct, input int unsigned stall_pct,
                                     input int unsigned phases);
      int unsigned size;
      int unsigned beats;
      logic [47:0] data;
      logic [2:0]  kind;
      bit          cut;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      for (int unsigned p = 0; p < phases; p++) begin
         wait_drained();
         kind = phase_kind(phase_count);
         cut  = (kind == KIND_SPARE) || ($urandom_range(5) == 0);
         if (kind == KIND_SPARE) size = $urandom_range(9000, 16383);
         else if ($urandom_range(5) == 0) size = $urandom_range(0, 63);
         else size = $urandom_range(64, 76);
         data = {16'($urandom), $urandom};
         data[13:0] = 14'(size);
         write_csr(REG_FRAME_SIZE, data);
         data = {16'($urandom), $urandom};
         data[2:0] = kind;
         write_csr(REG_FRAME_KIND, data);
         write_csr(REG_DEST_MAC, {16'($urandom), $urandom});
         write_csr(REG_SOURCE_MAC, {16'($urandom), $urandom});
         write_csr(REG_DEST_IPV4, {16'($urandom), $urandom});
         write_csr(REG_SOURCE_IPV4, {16'($urandom), $urandom});
         write_csr(REG_PORT_PAIR, {16'($urandom), $urandom});
         write_csr(REG_VLAN_TCI, {16'($urandom), $urandom});
         // Finish the frame left open, or send one whole frame, unless this phase is cut.
         if (cut) beats = $urandom_range(20, 60);
         else beats = bytes_left();
         for (int unsigned i = 0; i < beats; i++) begin
            if (p == 0 && i == beats / 2) wait_drained();
            send_random_beat();
         end
         phase_count++;
      end
   endtask

   task automatic finish_run();
      req_push = 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   endtask

   always @(negedge clock) rsp_pop = ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin : check_beats
      frame_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_beats.size() == 0) begin
            $error("beat with no expected byte: frame_byte %0h", rsp_frame_byte);
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_frame_byte !== want.frame_byte) begin
               $error("frame_byte: expected %0h, got %0h", want.frame_byte, rsp_frame_byte);
               mismatch_count++;
            end
            if (rsp_frame_start !== want.frame_start) begin
               $error("frame_start: expected %0b, got %0b", want.frame_start, rsp_frame_start);
               mismatch_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_frame_end);
               mismatch_count++;
            end
         end
      end
   end

   // Ends a hung run: counts cycles in which neither side moves a beat.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;
      test_reset_config();
      test_size_ceiling_arp_cut();
      test_unknown_kind_floor();
      test_random_frames(0, 0, 1);
      test_random_frames(69, 0, 2);
      test_random_frames(0, 69, 2);
      test_random_frames(32, 32, 1);
      finish_run();
   end

endmodule

// ----- sim.f -----
hw/rtl/efg_pkg.sv
hw/rtl/efg_fifo.sv
hw/rtl/efg_front.sv
hw/rtl/efg_csum.sv
hw/rtl/efg_back.sv
hw/rtl/ethernet_frame_generator.sv
tb/tb_top.sv
